// File: hdl/lms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lms_pkg;

    // Fixed field widths of the pixel and configuration channels.
    localparam int PIXEL_BITS     = 16;
    localparam int COLS_BITS      = 11;
    localparam int ROWS_BITS      = 13;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 13;

    // Default storage limits and register reset values.
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 4096;
    localparam int COLS_RESET   = 4;
    localparam int ROWS_RESET   = 4;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_COLS_IN_USE = 4'd0,
        REG_ROWS_IN_USE = 4'd1
    } cfg_reg_t;

    typedef struct packed {
        pixel_t pixel;
        logic   drain;
    } in_beat_t;

    typedef struct packed {
        pixel_t kept_value;
        logic   is_local_max;
        logic   last_of_frame;
    } out_beat_t;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  wdata;
    } cfg_beat_t;

    // What the position tracker knows about the result that an item releases.
    typedef struct packed {
        logic emit;
        logic up_ok;
        logic down_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } nbr_info_t;

endpackage

`default_nettype wire

// File: hdl/lms_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lms_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/lms_line_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One line of pixel history: a circular delay of one row, read before write.
module lms_line_cell
    import lms_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_COLS
) (
    input  wire                       clk,
    input  wire                       en,
    input  wire [$clog2(DEPTH)-1:0]   addr,
    input  wire pixel_t               wdata,
    output pixel_t                    rdata
);

    pixel_t mem [DEPTH];
    pixel_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mem[addr] <= wdata;
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/lms_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Frame geometry registers and the input and output position counters.
module lms_ctrl
    import lms_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire [CFG_DATA_BITS-1:0]      cfg_wdata,
    input  wire                          take,
    input  wire                          drain,
    output logic                         push,
    output nbr_info_t                    info,
    output logic [$clog2(MAX_COLS)-1:0]  ptr
);

    localparam int CIDX_W = $clog2(MAX_COLS);
    localparam int RIDX_W = $clog2(MAX_ROWS);
    localparam int FILL_W = $clog2(MAX_COLS + 1);

    function automatic logic [CIDX_W-1:0] col_last(input logic [COLS_BITS-1:0] v);
        logic [CIDX_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (32'(v) > 32'(MAX_COLS))
            r = CIDX_W'(MAX_COLS - 1);
        else
            r = CIDX_W'(32'(v) - 32'd1);
        return r;
    endfunction

    function automatic logic [RIDX_W-1:0] row_last(input logic [ROWS_BITS-1:0] v);
        logic [RIDX_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (32'(v) > 32'(MAX_ROWS))
            r = RIDX_W'(MAX_ROWS - 1);
        else
            r = RIDX_W'(32'(v) - 32'd1);
        return r;
    endfunction

    logic [CIDX_W-1:0] w_last_reg, w_last_next;
    logic [RIDX_W-1:0] h_last_reg, h_last_next;
    logic [CIDX_W-1:0] in_col_reg, in_col_next;
    logic [RIDX_W-1:0] in_row_reg, in_row_next;
    logic              in_done_reg, in_done_next;
    logic [CIDX_W-1:0] out_col_reg, out_col_next;
    logic [RIDX_W-1:0] out_row_reg, out_row_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              armed_reg, armed_next;
    logic [CIDX_W-1:0] ptr_reg, ptr_next;
    logic              restart;

    // A pixel is taken until the frame's last pixel is in; a drain only after it.
    assign push = take && (drain ? in_done_reg : !in_done_reg);

    assign info.emit     = armed_reg;
    assign info.up_ok    = (out_row_reg != '0);
    assign info.down_ok  = (out_row_reg != h_last_reg);
    assign info.left_ok  = (out_col_reg != '0);
    assign info.right_ok = (out_col_reg != w_last_reg);
    assign info.last     = (out_row_reg == h_last_reg) && (out_col_reg == w_last_reg);
    assign ptr           = ptr_reg;

    always_comb
    begin
        w_last_next  = w_last_reg;
        h_last_next  = h_last_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        fill_next    = fill_reg;
        armed_next   = armed_reg;
        ptr_next     = ptr_reg;
        restart      = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_COLS_IN_USE:
                begin
                    w_last_next = col_last(cfg_wdata[COLS_BITS-1:0]);
                    restart     = 1'b1;
                end
                REG_ROWS_IN_USE:
                begin
                    h_last_next = row_last(cfg_wdata[ROWS_BITS-1:0]);
                    restart     = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (push)
        begin
            ptr_next = (ptr_reg == w_last_reg) ? '0 : ptr_reg + 1'b1;

            // Results start once a full row plus one item is in the history.
            if (!armed_reg)
            begin
                if (fill_reg == FILL_W'(w_last_reg) + FILL_W'(1))
                    armed_next = 1'b1;
                else
                    fill_next = fill_reg + 1'b1;
            end

            if (!drain)
            begin
                if (in_col_reg == w_last_reg)
                begin
                    in_col_next = '0;
                    if (in_row_reg == h_last_reg)
                        in_done_next = 1'b1;
                    else
                        in_row_next = in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end

            if (armed_reg)
            begin
                if (info.last)
                begin
                    restart = 1'b1;
                end
                else if (out_col_reg == w_last_reg)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end

        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            in_done_next = 1'b0;
            out_col_next = '0;
            out_row_next = '0;
            fill_next    = '0;
            armed_next   = 1'b0;
            ptr_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg  <= col_last(COLS_BITS'(COLS_RESET));
            h_last_reg  <= row_last(ROWS_BITS'(ROWS_RESET));
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_done_reg <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            fill_reg    <= '0;
            armed_reg   <= 1'b0;
            ptr_reg     <= '0;
        end
        else
        begin
            w_last_reg  <= w_last_next;
            h_last_reg  <= h_last_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_done_reg <= in_done_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            fill_reg    <= fill_next;
            armed_reg   <= armed_next;
            ptr_reg     <= ptr_next;
        end
    end

    // After the frame's final result every position is back at the origin.
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && info.emit && info.last) |=>
            (out_row_reg == '0 && out_col_reg == '0 && !armed_reg && !in_done_reg))
        else $error("positions not cleared after the last result of a frame");

    // The output position never runs ahead of the input rows.
    a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
        !in_done_reg |-> (out_row_reg <= in_row_reg))
        else $error("output row ahead of input row");

endmodule

`default_nettype wire

// File: hdl/lms_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-entry result buffer, so the pipeline keeps moving while one result waits.
module lms_out_skid
    import lms_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  wire out_beat_t        push_data,
    output logic                  space,
    lms_stream_if.source          results
);

    logic [1:0] count_reg, count_next;
    out_beat_t  slot0_reg, slot0_next;
    out_beat_t  slot1_reg, slot1_next;
    logic       pop;

    assign pop           = results.valid && results.ready;
    assign results.valid = (count_reg != 2'd0);
    assign results.data  = slot0_reg;
    assign space         = (count_reg != 2'd2) || results.ready;

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    slot0_next = push_data;
                else
                    slot1_next = push_data;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    slot0_next = push_data;
                end
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = push_data;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2 || pop))
        else $error("result written into a full buffer");

endmodule

`default_nettype wire

// File: hdl/local_maximum_suppression.sv
`timescale 1ns / 1ps
`default_nettype none

// Four-neighbour local maximum suppression over a raster-scanned frame. Pixels
// come in one per beat on the pixels channel; for each pixel the block returns
// the original value with is_local_max set when no in-frame up, down, left or
// right neighbour is strictly greater, and zero otherwise, with ties kept. A
// result appears on the beat that brings the pixel one row and one pixel later,
// so after the frame's last pixel the user sends drain beats (about one row
// plus one of them) to flush the rest; the final result carries last_of_frame,
// and the next pixel then starts a new frame. Drain beats before the last pixel
// and pixel beats while a frame is being flushed are taken and dropped. The
// block takes one beat per clock while the result buffer has room and gives at
// most one result per beat; a beat passes stages B and C to the result buffer,
// beside the two-stage chain of line memories with registered reads. Each line
// memory has one port that writes and reads the same address once per beat. A
// write on the cfg channel sets the row width or frame height and restarts the
// frame; it is meant for an idle block, with no results still pending.
module local_maximum_suppression
    import lms_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire            clk,
    input  wire            rst_n,
    lms_stream_if.sink     pixels,
    lms_stream_if.source   results,
    lms_stream_if.sink     cfg
);

    localparam int CIDX_W = $clog2(MAX_COLS);
    localparam int LINES  = 2;

    // The whole pixel path moves in lockstep whenever the result buffer has room.
    logic              adv;
    logic              take;
    logic              push;
    nbr_info_t         push_info;
    logic [CIDX_W-1:0] push_ptr;
    pixel_t            x_in;

    // Pipeline stage B: the line memory read of the newest item is on its way.
    logic              b_valid_reg;
    pixel_t            b_x_reg;
    logic [CIDX_W-1:0] b_ptr_reg;
    nbr_info_t         b_info_reg;

    // Window registers along the middle row, plus the previous item (down).
    pixel_t            c1_reg;
    pixel_t            c2_reg;
    pixel_t            down_reg;

    // Pipeline stage C: all five operands are present.
    logic              c_valid_reg;
    nbr_info_t         c_info_reg;
    pixel_t            c_right_reg;
    pixel_t            c_centre_reg;
    pixel_t            c_left_reg;
    pixel_t            c_down_reg;

    logic              cell_en    [LINES];
    logic [CIDX_W-1:0] cell_addr  [LINES];
    pixel_t            cell_wdata [LINES];
    pixel_t            cell_rdata [LINES];

    logic              beaten;
    out_beat_t         result;
    logic              result_push;

    assign pixels.ready = adv;
    assign cfg.ready    = 1'b1;
    assign take         = pixels.valid && pixels.ready;
    assign x_in         = pixels.data.drain ? '0 : pixels.data.pixel;

    lms_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid && cfg.ready),
        .cfg_index (cfg.data.index),
        .cfg_wdata (cfg.data.wdata),
        .take      (take),
        .drain     (pixels.data.drain),
        .push      (push),
        .info      (push_info),
        .ptr       (push_ptr)
    );

    // The first line delays the incoming stream by one row; the second delays
    // the centre column by another row, which gives the pixel above the centre.
    assign cell_en[0]    = push;
    assign cell_addr[0]  = push_ptr;
    assign cell_wdata[0] = x_in;
    assign cell_en[1]    = b_valid_reg && adv;
    assign cell_addr[1]  = b_ptr_reg;
    assign cell_wdata[1] = c1_reg;

    for (genvar i = 0; i < LINES; i++)
    begin : g_line
        lms_line_cell #(
            .DEPTH (MAX_COLS)
        ) u_line (
            .clk   (clk),
            .en    (cell_en[i]),
            .addr  (cell_addr[i]),
            .wdata (cell_wdata[i]),
            .rdata (cell_rdata[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= push;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            b_x_reg    <= x_in;
            b_ptr_reg  <= push_ptr;
            b_info_reg <= push_info;
        end
        if (b_valid_reg && adv)
        begin
            c1_reg       <= cell_rdata[0];
            c2_reg       <= c1_reg;
            down_reg     <= b_x_reg;
            c_info_reg   <= b_info_reg;
            c_right_reg  <= cell_rdata[0];
            c_centre_reg <= c1_reg;
            c_left_reg   <= c2_reg;
            c_down_reg   <= down_reg;
        end
    end

    // The up neighbour arrives from the second line memory in this stage.
    assign beaten = (c_info_reg.up_ok    && (cell_rdata[1] > c_centre_reg))
                 || (c_info_reg.down_ok  && (c_down_reg    > c_centre_reg))
                 || (c_info_reg.left_ok  && (c_left_reg    > c_centre_reg))
                 || (c_info_reg.right_ok && (c_right_reg   > c_centre_reg));

    assign result.kept_value    = beaten ? '0 : c_centre_reg;
    assign result.is_local_max  = !beaten;
    assign result.last_of_frame = c_info_reg.last;
    assign result_push          = adv && c_valid_reg && c_info_reg.emit;

    lms_out_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_push),
        .push_data (result),
        .space     (adv),
        .results   (results)
    );

    // An item that releases a result reaches the compare stage after one more step.
    a_emit_reaches_compare: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_info.emit) ##1 adv |=> (c_valid_reg && c_info_reg.emit))
        else $error("releasing item lost between pipeline stages");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

import lms_pkg::*;

class maxima_scoreboard;
    logic [COLS_BITS-1:0] cols_reg;
    logic [ROWS_BITS-1:0] rows_reg;
    pixel_t               line_history [2*DEF_MAX_COLS+1];
    int unsigned          in_row;
    int unsigned          in_col;
    int unsigned          out_row;
    int unsigned          out_col;
    int unsigned          beat_count;
    int unsigned          wr_ptr;
    out_beat_t            pending_maxima [$];
    int unsigned          frames_finished;
    int unsigned          beats_used;
    int unsigned          mismatches;

    function new();
        cols_reg = COLS_BITS'(COLS_RESET);
        rows_reg = ROWS_BITS'(ROWS_RESET);
        foreach (line_history[i])
        begin
            line_history[i] = '0;
        end
        restart_frame();
        frames_finished = 0;
        beats_used = 0;
        mismatches = 0;
    endfunction

    function void restart_frame();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        beat_count = 0;
        wr_ptr = 0;
    endfunction

    function int unsigned frame_cols();
        if (cols_reg == 0)
        begin
            return 1;
        end
        if (cols_reg > DEF_MAX_COLS)
        begin
            return DEF_MAX_COLS;
        end
        return int'(cols_reg);
    endfunction

    function int unsigned frame_rows();
        if (rows_reg == 0)
        begin
            return 1;
        end
        if (rows_reg > DEF_MAX_ROWS)
        begin
            return DEF_MAX_ROWS;
        end
        return int'(rows_reg);
    endfunction

    // True once every pixel of the frame is in and only drain beats advance it.
    function bit flushing();
        return in_row >= frame_rows();
    endfunction

    function void note_config(cfg_beat_t beat);
        if (beat.index == REG_COLS_IN_USE)
        begin
            cols_reg = beat.wdata[COLS_BITS-1:0];
            restart_frame();
        end
        else if (beat.index == REG_ROWS_IN_USE)
        begin
            rows_reg = beat.wdata[ROWS_BITS-1:0];
            restart_frame();
        end
    endfunction

    // Value stored the given number of beats before the newest one.
    function pixel_t look_back(int unsigned depth, int unsigned span);
        return line_history[(wr_ptr + span - 1 - depth) % span];
    endfunction

    function void note_pixel_beat(in_beat_t beat);
        int unsigned w;
        int unsigned h;
        int unsigned span;
        pixel_t      centre;
        bit          beaten;
        bit          emit;
        out_beat_t   want;
        w = frame_cols();
        h = frame_rows();
        span = 2 * w + 1;
        if (wr_ptr >= span)
        begin
            wr_ptr = 0;
        end
        if (!beat.drain && in_row >= h)
        begin
            return;
        end
        if (beat.drain && (in_row < h || out_row >= h))
        begin
            return;
        end
        beats_used++;
        emit = beat_count >= w + 1;
        if (emit)
        begin
            centre = look_back(w, span);
            beaten = 1'b0;
            if (out_row > 0 && look_back(2 * w, span) > centre)
            begin
                beaten = 1'b1;
            end
            if (out_row + 1 < h && look_back(0, span) > centre)
            begin
                beaten = 1'b1;
            end
            if (out_col > 0 && look_back(w + 1, span) > centre)
            begin
                beaten = 1'b1;
            end
            if (out_col + 1 < w && look_back(w - 1, span) > centre)
            begin
                beaten = 1'b1;
            end
            want.kept_value = beaten ? '0 : centre;
            want.is_local_max = !beaten;
            want.last_of_frame = (out_row + 1 == h) && (out_col + 1 == w);
            pending_maxima.push_back(want);
        end
        line_history[wr_ptr] = beat.drain ? '0 : beat.pixel;
        wr_ptr = (wr_ptr + 1) % span;
        beat_count++;
        if (!beat.drain)
        begin
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
        end
        if (emit)
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
            if (out_row >= h)
            begin
                restart_frame();
                frames_finished++;
            end
        end
    endfunction

    function void check_result(out_beat_t got);
        out_beat_t want;
        if (pending_maxima.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result kept_value=%0d is_local_max=%0b last_of_frame=%0b",
                     $time, got.kept_value, got.is_local_max, got.last_of_frame);
            return;
        end
        want = pending_maxima.pop_front();
        if (got.kept_value !== want.kept_value)
        begin
            mismatches++;
            $display("%0t: kept_value expected %0d actual %0d",
                     $time, want.kept_value, got.kept_value);
        end
        if (got.is_local_max !== want.is_local_max)
        begin
            mismatches++;
            $display("%0t: is_local_max expected %0b actual %0b",
                     $time, want.is_local_max, got.is_local_max);
        end
        if (got.last_of_frame !== want.last_of_frame)
        begin
            mismatches++;
            $display("%0t: last_of_frame expected %0b actual %0b",
                     $time, want.last_of_frame, got.last_of_frame);
        end
    endfunction
endclass

module tb_top;

    // A beat passes stages B and C between the pixel port and the result buffer, so
    // SETTLE_CYCLES quiet cycles are more than enough for beats that release no result.
    localparam int SETTLE_CYCLES = 8;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_BEATS  = 280;

    // An index past the last register; a write to it must change nothing.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = '1;

    // A frame length that is never reached, so the frame runs to its end.
    localparam int unsigned NO_ABORT = 32'hFFFF_FFFF;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum int
    {
        PIX_ANY,
        PIX_TIES,
        PIX_EXTREME
    } pixel_style_t;

    logic             clk = 1'b0;
    logic             rst_n;
    int               sender_idle_pct;
    int               receiver_stall_pct;
    int unsigned      cycles;
    maxima_scoreboard sb;

    lms_stream_if #(.T(in_beat_t))  pixels ();
    lms_stream_if #(.T(out_beat_t)) results ();
    lms_stream_if #(.T(cfg_beat_t)) cfg ();

    local_maximum_suppression i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels),
        .results (results),
        .cfg     (cfg)
    );

    always #5 clk = ~clk;

    // All three channels are watched at the rising edge. A register write only
    // happens while the block is quiet, so its place in this order is harmless;
    // a result always stems from a beat taken at an earlier edge.
    always @(posedge clk)
    begin
        if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
        begin
            sb.note_config(cfg.data);
        end
        if (pixels.valid === 1'b1 && pixels.ready === 1'b1)
        begin
            sb.note_pixel_beat(pixels.data);
        end
        if (results.valid === 1'b1 && results.ready === 1'b1)
        begin
            sb.check_result(results.data);
        end
    end

    // The receiver draws a fresh stall decision every cycle.
    always @(negedge clk)
    begin
        results.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    function automatic void set_idle_mode(idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                sender_idle_pct = 66;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 66;
            end
            IDLE_BOTH:
            begin
                sender_idle_pct = 24;
                receiver_stall_pct = 24;
            end
            default:
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
        endcase
    endfunction

    function automatic pixel_t pick_pixel(pixel_style_t style);
        case (style)
            PIX_TIES:
            begin
                // A tiny range makes equal neighbours common.
                return pixel_t'($urandom_range(0, 3));
            end
            PIX_EXTREME:
            begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return pixel_t'(1);
                    default: return {1'b1, {(PIXEL_BITS-1){1'b0}}};
                endcase
            end
            default:
            begin
                return pixel_t'($urandom_range(0, 65535));
            end
        endcase
    endfunction

    // Every driving task starts and ends just after a falling edge at which
    // nothing has been assigned yet, so each signal gets at most one update per
    // time step and valid may stay high from one beat to the next.
    task automatic send_pixel_beat(input in_beat_t beat);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            pixels.valid <= 1'b0;
            @(negedge clk);
        end
        pixels.valid <= 1'b1;
        pixels.data  <= beat;
        do
            @(posedge clk);
        while (pixels.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic send_drain();
        in_beat_t beat;
        beat.pixel = pick_pixel(PIX_ANY);
        beat.drain = 1'b1;
        send_pixel_beat(beat);
    endtask

    task automatic send_pixel(input pixel_t value);
        in_beat_t beat;
        beat.pixel = value;
        beat.drain = 1'b0;
        send_pixel_beat(beat);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_beat_t beat;
        beat.index = index;
        beat.wdata = value;
        cfg.valid <= 1'b1;
        cfg.data  <= beat;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop sending, let every expected result come out, then give beats that
    // release no result time to leave the pipeline.
    task automatic wait_until_quiet();
        pixels.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending_maxima.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_BITS-1:0] cols_word,
                             input logic [CFG_DATA_BITS-1:0] rows_word);
        wait_until_quiet();
        if ($urandom_range(0, 1) == 1)
        begin
            write_register(REG_COLS_IN_USE, cols_word);
            write_register(REG_ROWS_IN_USE, rows_word);
        end
        else
        begin
            write_register(REG_ROWS_IN_USE, rows_word);
            write_register(REG_COLS_IN_USE, cols_word);
        end
    endtask

    // Sends one frame: pixels until the frame is full, then drain beats until
    // the flagged last result has been predicted. About one beat in twenty is
    // of the wrong kind (a drain too early or a pixel during the flush), which
    // the block must drop. A frame may be cut short after a number of used
    // beats; the register write that follows then aborts it.
    task automatic run_frame(input pixel_style_t style, input int unsigned abort_after);
        int unsigned frames_at_start;
        int unsigned beats_at_start;
        in_beat_t    beat;
        frames_at_start = sb.frames_finished;
        beats_at_start = sb.beats_used;
        while (sb.frames_finished == frames_at_start &&
               sb.beats_used - beats_at_start < abort_after)
        begin
            beat.pixel = pick_pixel(style);
            beat.drain = sb.flushing();
            if ($urandom_range(0, 19) == 0)
            begin
                beat.drain = !beat.drain;
            end
            send_pixel_beat(beat);
        end
    endtask

    initial
    begin
        pixel_t                    opening [16];
        int unsigned               frames_at_start;
        int unsigned               random_start;
        int unsigned               phase;
        int unsigned               frame_total;
        int unsigned               abort_after;
        logic [CFG_DATA_BITS-1:0]  cols_word;
        logic [CFG_DATA_BITS-1:0]  rows_word;

        sb = new();
        rst_n = 1'b0;
        pixels.valid = 1'b0;
        pixels.data = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        results.ready = 1'b0;
        set_idle_mode(IDLE_NONE);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed frame on the reset size of four by four. It holds both value
        // extremes, equal neighbours, plateaus and lone peaks, and border pixels
        // that have fewer than four neighbours.
        opening = '{16'hFFFF, 16'h0000, 16'h0007, 16'h0007,
                    16'h0000, 16'hFFFF, 16'h0007, 16'h0003,
                    16'h0005, 16'h0005, 16'h0005, 16'h0000,
                    16'h0001, 16'hFFFF, 16'h8000, 16'hFFFF};
        frames_at_start = sb.frames_finished;
        foreach (opening[i])
        begin
            // A drain beat in the middle of the frame must be ignored.
            if (i == 8)
            begin
                send_drain();
            end
            send_pixel(opening[i]);
        end
        // The first drain releases a result; the pixel after it comes while the
        // frame is being flushed and must be dropped.
        send_drain();
        send_pixel(16'h5A5A);
        while (sb.frames_finished == frames_at_start)
        begin
            send_drain();
        end

        // A write to an index past the last register leaves the size alone.
        wait_until_quiet();
        write_register(REG_UNUSED, '1);
        run_frame(PIX_ANY, NO_ABORT);

        // Extreme sizes. A zero column count means one column and the largest
        // row word is clamped to the row limit, so this is a single tall column,
        // cut short after a few dozen beats.
        set_idle_mode(IDLE_BOTH);
        configure(13'd0, {CFG_DATA_BITS{1'b1}});
        run_frame(PIX_ANY, 40);

        // The largest column word and a zero row count: a single full-width row,
        // where the first drain releases nothing. It is cut short once a few
        // results have come out, which already needs the full row delay.
        set_idle_mode(IDLE_RECEIVER);
        configure(13'h07FF, 13'd0);
        run_frame(PIX_TIES, 1040);

        // One pixel per frame, several frames back to back.
        set_idle_mode(IDLE_SENDER);
        configure(13'd1, 13'd1);
        repeat (3) run_frame(PIX_EXTREME, NO_ABORT);

        // Random part: mostly small frames, each phase with its own size and its
        // own way of idling, so that gaps land on every stage of the work.
        phase = 0;
        random_start = sb.beats_used;
        while (sb.beats_used - random_start < RANDOM_BEATS)
        begin
            set_idle_mode(idle_mode_t'(phase % 4));
            case ($urandom_range(0, 9))
                0: cols_word = 13'd0;
                1, 2: cols_word = CFG_DATA_BITS'($urandom_range(9, 40));
                default: cols_word = CFG_DATA_BITS'($urandom_range(1, 8));
            endcase
            // The upper bits of the word lie outside the column register.
            if ($urandom_range(0, 3) == 0)
            begin
                cols_word[CFG_DATA_BITS-1:COLS_BITS] =
                    (CFG_DATA_BITS-COLS_BITS)'($urandom_range(1, 3));
            end
            case ($urandom_range(0, 9))
                0: rows_word = 13'd0;
                1: rows_word = CFG_DATA_BITS'($urandom_range(9, 20));
                default: rows_word = CFG_DATA_BITS'($urandom_range(1, 8));
            endcase
            configure(cols_word, rows_word);
            frame_total = $urandom_range(1, 3);
            for (int f = 0; f < frame_total; f++)
            begin
                abort_after = NO_ABORT;
                if (f == frame_total - 1 && $urandom_range(0, 5) == 0)
                begin
                    abort_after = $urandom_range(1, 40);
                end
                run_frame(pixel_style_t'($urandom_range(0, 2)), abort_after);
            end
            phase++;
        end

        wait_until_quiet();
        if (sb.mismatches == 0 && sb.pending_maxima.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Guards against a block that stops answering.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run stopped after %0d cycles with %0d results outstanding",
                 $time, CYCLE_LIMIT, sb.pending_maxima.size());
        $display("FAILURE");
        $finish;
    end

endmodule
